FILE: design/dq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Request and status codes and shared types of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    typedef logic [2:0] t_req;
    typedef logic [1:0] t_status;

    // Request codes; codes above REQ_QUERY behave as a query
    localparam t_req REQ_PUSH_BACK  = 3'd0;
    localparam t_req REQ_PUSH_FRONT = 3'd1;
    localparam t_req REQ_POP_FRONT  = 3'd2;
    localparam t_req REQ_POP_BACK   = 3'd3;
    localparam t_req REQ_QUERY      = 3'd4;

    // Status codes
    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_POP_EMPTY  = 2'd1;
    localparam t_status ST_PUSH_FULL  = 2'd2;

    // Control to storage and result path
    typedef struct packed {
        logic    wr_en;
        t_status status;
    } t_ctrl_stat;

endpackage : dq_pkg
`default_nettype wire

FILE: design/double_ended_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed 32-bit values in a ring of slots.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  request   i_valid / o_ready    i_req_type, i_push_value
//  result    o_valid / i_ready    o_front_value, o_back_value, o_entry_total,
//                                 o_is_empty, o_status
//
//  Each request passes through pointer update and slot write, read of
//  the front and back slots, then capture of the read data into the result
//  register. The slot memory's registered read data calls for the read stage.
//  Reset clears indices, count and handshake state; slot contents are kept.
//  A new request is taken while a result waits; a stalled result holds the
//  next one in the read-data stage.
// ----------------------------------------------------------------------------
module double_ended_queue_top
    import dq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [2:0]                     i_req_type,
    input  wire logic signed [31:0]             i_push_value,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [31:0]                  o_front_value,
    output logic signed [31:0]                  o_back_value,
    output logic [$clog2(DEPTH+1)-1:0]          o_entry_total,
    output logic                                o_is_empty,
    output logic [1:0]                          o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DATA = 2'd2;

    logic [1:0]          r_state, n_state;
    logic                r_out_valid, n_out_valid;
    logic signed [31:0]  r_front_val, r_back_val;
    logic [CW-1:0]       r_total;
    logic                r_empty;
    t_status             r_status;
    logic                acc, load_out;
    t_ctrl_stat          stat;
    logic [AW-1:0]       wr_addr, front_idx, back_idx;
    logic [CW-1:0]       count;
    logic signed [31:0]  rd_front, rd_back;

    assign acc = i_valid && o_ready;

    dq_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (acc),
        .i_req       (i_req_type),
        .o_stat      (stat),
        .o_wr_addr   (wr_addr),
        .o_front_idx (front_idx),
        .o_back_idx  (back_idx),
        .o_count     (count)
    );

    dq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (stat.wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_push_value),
        .i_rd_addr_a (front_idx),
        .i_rd_addr_b (back_idx),
        .o_rd_data_a (rd_front),
        .o_rd_data_b (rd_back)
    );

    // Advance the item through update, read and capture
    assign load_out = (r_state == S_DATA) && (!r_out_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (acc) n_state = S_READ;
            S_READ: n_state = S_DATA;
            S_DATA: if (load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the result; empty queue shows -1 at both ends
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_front_val <= (count == '0) ? '1 : rd_front;
            r_back_val  <= (count == '0) ? '1 : rd_back;
            r_total     <= count;
            r_empty     <= (count == '0);
            r_status    <= stat.status;
        end
    end

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_front_value = r_front_val;
    assign o_back_value  = r_back_val;
    assign o_entry_total = r_total;
    assign o_is_empty    = r_empty;
    assign o_status      = r_status;

    // Slot writes only happen on an accepted item
    a_wr_on_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.wr_en |-> acc)
        else $error("slot write without accepted item");

    // An accepted item moves to the read stage
    a_acc_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> (r_state == S_READ))
        else $error("accepted item did not reach read stage");

    // Pointers are stable while the slots are being read
    a_ptr_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DATA) |-> ($stable(front_idx) && $stable(back_idx) && $stable(count)))
        else $error("pointers moved during read");

endmodule : double_ended_queue_top
`default_nettype wire

FILE: design/dq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ram
// Slot storage: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [AW-1:0]        i_wr_addr,
    input  wire logic signed [31:0]   i_wr_data,
    input  wire logic [AW-1:0]        i_rd_addr_a,
    input  wire logic [AW-1:0]        i_rd_addr_b,
    output logic signed [31:0]        o_rd_data_a,
    output logic signed [31:0]        o_rd_data_b
);

    logic signed [31:0] r_mem [DEPTH];

    // Write the slot
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read both ports; the read data is registered
    always_ff @(posedge i_clk) begin
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule : dq_ram
`default_nettype wire

FILE: design/dq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Front and back indices and entry count; decodes a request into the
// slot write and the next pointer state.
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int CW    = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_acc,
    input  wire t_req                 i_req,
    output t_ctrl_stat                o_stat,
    output logic [AW-1:0]             o_wr_addr,
    output logic [AW-1:0]             o_front_idx,
    output logic [AW-1:0]             o_back_idx,
    output logic [CW-1:0]             o_count
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);

    logic [AW-1:0] r_front, n_front;
    logic [AW-1:0] r_back,  n_back;
    logic [CW-1:0] r_count, n_count;
    t_status       r_status, n_status;
    logic          is_push, is_pop, is_empty, is_full, wr_en;
    logic [AW-1:0] wr_addr, front_prev, front_next, back_prev, back_next;

    // Decode request class
    always_comb begin
        is_push = 1'b0;
        is_pop  = 1'b0;
        unique case (i_req) inside
            REQ_PUSH_BACK, REQ_PUSH_FRONT: is_push = 1'b1;
            REQ_POP_FRONT, REQ_POP_BACK:   is_pop  = 1'b1;
            default: ;
        endcase
    end

    // Neighbouring ring indices
    assign front_next = (r_front == LAST_IDX) ? '0 : r_front + AW'(1);
    assign front_prev = (r_front == '0) ? LAST_IDX : r_front - AW'(1);
    assign back_next  = (r_back == LAST_IDX) ? '0 : r_back + AW'(1);
    assign back_prev  = (r_back == '0) ? LAST_IDX : r_back - AW'(1);

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == FULL_CNT);

    // Next pointer state and slot write
    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        n_status = r_status;
        wr_en    = 1'b0;
        wr_addr  = r_front;
        if (i_acc) begin
            n_status = ST_OK;
            if (is_push) begin
                if (is_full) begin
                    n_status = ST_PUSH_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + ONE_CNT;
                    if (is_empty) begin
                        n_back  = r_front;
                        wr_addr = r_front;
                    end else if (i_req == REQ_PUSH_BACK) begin
                        n_back  = back_next;
                        wr_addr = back_next;
                    end else begin
                        n_front = front_prev;
                        wr_addr = front_prev;
                    end
                end
            end else if (is_pop) begin
                if (is_empty) begin
                    n_status = ST_POP_EMPTY;
                end else begin
                    n_count = r_count - ONE_CNT;
                    if (r_count != ONE_CNT) begin
                        if (i_req == REQ_POP_FRONT) begin
                            n_front = front_next;
                        end else begin
                            n_back = back_prev;
                        end
                    end
                end
            end
        end
    end

    // Hold pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_back   <= '0;
            r_count  <= '0;
            r_status <= ST_OK;
        end else begin
            r_front  <= n_front;
            r_back   <= n_back;
            r_count  <= n_count;
            r_status <= n_status;
        end
    end

    assign o_stat.wr_en  = wr_en;
    assign o_stat.status = r_status;
    assign o_wr_addr     = wr_addr;
    assign o_front_idx   = r_front;
    assign o_back_idx    = r_back;
    assign o_count       = r_count;

    // Count never exceeds the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond capacity");

    // A rejected push leaves the count alone
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && is_push && is_full) |=> (r_count == FULL_CNT && r_status == ST_PUSH_FULL))
        else $error("push on full changed state");

    // A rejected pop leaves the queue empty
    a_empty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && is_pop && is_empty) |=> (r_count == '0 && r_status == ST_POP_EMPTY))
        else $error("pop on empty changed state");

endmodule : dq_ctrl
`default_nettype wire
